// ----- design/rsi_pkg.sv -----
// shared types and constants for the ray / sphere intersector
// no dependencies
package rsi_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CENTER_X   = 3'd0,
        CFG_CENTER_Y   = 3'd1,
        CFG_CENTER_Z   = 3'd2,
        CFG_RADIUS     = 3'd3,
        CFG_INV_RADIUS = 3'd4,
        CFG_EPSILON    = 3'd5
    } cfg_idx_t;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 152;
    localparam int SQRT_STEPS = 29;

    localparam logic [22:0] RADIUS_RST  = 23'd4096;
    localparam logic [22:0] INV_RAD_RST = 23'd4096;
    localparam logic [11:0] EPS_RST     = 12'd1;

    // ray as it travels down the pipeline
    typedef struct packed {
        logic [23:0] ox;
        logic [23:0] oy;
        logic [23:0] oz;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
    } ray_t;

endpackage

// ----- design/ray_sphere_intersect.sv -----
// ray / sphere intersection pipeline, one sphere held in configuration registers
// depends on rsi_pkg
//
// Each input word is one ray (origin Q12.12, unit direction Q1.14), tested against
// the configured sphere. The block is a fully pipelined datapath of 40 register
// stages: a new ray may enter every cycle unless the pipeline is full and the
// output is stalled. Most of the stages form the integer square root, which
// resolves one result bit per stage over 29 stages; the remaining stages hold
// multipliers or wide adds. Each stage has its own valid bit and takes a new word
// whenever it is empty or its successor moves, so bubbles are squeezed out and the
// input keeps flowing while a result waits at the output, until the pipeline fills.
// Configuration registers are to be written only while the pipeline is empty; the
// block itself does not enforce this. cfg_ready is always high. A miss returns an all-zero result word.
module ray_sphere_intersect (
    input  logic                             clk,
    input  logic                             rst_n,
    // ox[23:0] oy[47:24] oz[71:48] dx[87:72] dy[103:88] dz[119:104]
    input  logic [rsi_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // hit[0] distance[24:1] point_x[48:25] point_y[72:49] point_z[96:73]
    // surf_nx[112:97] surf_ny[128:113] surf_nz[144:129] zero pad[151:145]
    output logic [rsi_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [2:0]                       cfg_index,
    input  logic [23:0]                      cfg_data
);
    import rsi_pkg::*;

    localparam int NST     = 40;
    localparam int SQ_BASE = 5;
    localparam int ST_T    = SQ_BASE + SQRT_STEPS;   // 34
    localparam int ST_DT   = ST_T + 1;
    localparam int ST_P    = ST_T + 2;
    localparam int ST_PC   = ST_T + 3;
    localparam int ST_NP   = ST_T + 4;
    localparam int ST_OUT  = ST_T + 5;               // 39

    // stage payload types
    typedef struct packed {
        ray_t               ray;
        logic signed [24:0] lx, ly, lz;
    } s1_t;

    typedef struct packed {
        ray_t               ray;
        logic signed [40:0] pdx, pdy, pdz;
        logic signed [49:0] plx, ply, plz;
        logic [45:0]        rr;
    } s2_t;

    typedef struct packed {
        ray_t               ray;
        logic signed [28:0] b;
        logic signed [51:0] ll;
        logic [45:0]        rr;
    } s3_t;

    typedef struct packed {
        ray_t               ray;
        logic signed [28:0] b;
        logic signed [57:0] bb;
        logic signed [51:0] ll;
        logic [45:0]        rr;
    } s4_t;

    typedef struct packed {
        ray_t               ray;
        logic signed [28:0] b;
        logic signed [58:0] disc;
    } s5_t;

    typedef struct packed {
        ray_t        ray;
        logic [28:0] b;
        logic        neg;
        logic        tan;
        logic [57:0] v;
        logic [31:0] rem;
        logic [28:0] root;
    } sq_t;

    typedef struct packed {
        ray_t               ray;
        logic signed [30:0] t;
        logic               miss;
    } st_t;

    typedef struct packed {
        logic [23:0]        ox, oy, oz;
        logic signed [30:0] t;
        logic               miss;
        logic signed [46:0] dtx, dty, dtz;
    } sdt_t;

    typedef struct packed {
        logic signed [30:0] t;
        logic               miss;
        logic signed [33:0] px, py, pz;
    } sp_t;

    typedef struct packed {
        logic [23:0]        distance;
        logic               miss;
        logic [23:0]        ptx, pty, ptz;
        logic signed [34:0] pcx, pcy, pcz;
    } spc_t;

    typedef struct packed {
        logic [23:0]        distance;
        logic               miss;
        logic [23:0]        ptx, pty, ptz;
        logic signed [58:0] nx, ny, nz;
    } snp_t;

    // saturate a hit point coordinate to signed 24 bits
    function automatic logic [23:0] sat_point(input logic signed [33:0] x);
        logic [23:0] r;
        if (x > 34'sd8388607)
            r = 24'h7FFFFF;
        else if (x < -34'sd8388608)
            r = 24'h800000;
        else
            r = x[23:0];
        return r;
    endfunction

    // round Q.24 product to Q.14 and clamp to +-1.0
    function automatic logic [15:0] sat_normal(input logic signed [58:0] x);
        logic signed [58:0] rnd;
        logic signed [48:0] n;
        logic [15:0]        r;
        rnd = x + 59'sd512;
        n = rnd[58:10];
        if (n > 49'sd16384)
            r = 16'sd16384;
        else if (n < -49'sd16384)
            r = -16'sd16384;
        else
            r = n[15:0];
        return r;
    endfunction

    // configuration registers
    logic [23:0] center_x_reg, center_y_reg, center_z_reg;
    logic [22:0] radius_reg, inv_radius_reg;
    logic [11:0] epsilon_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            center_z_reg   <= '0;
            radius_reg     <= RADIUS_RST;
            inv_radius_reg <= INV_RAD_RST;
            epsilon_reg    <= EPS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CENTER_X:   center_x_reg   <= cfg_data;
                CFG_CENTER_Y:   center_y_reg   <= cfg_data;
                CFG_CENTER_Z:   center_z_reg   <= cfg_data;
                CFG_RADIUS:     radius_reg     <= cfg_data[22:0];
                CFG_INV_RADIUS: inv_radius_reg <= cfg_data[22:0];
                CFG_EPSILON:    epsilon_reg    <= cfg_data[11:0];
                default:        ;
            endcase
        end
    end

    // pipeline flow control: a stage loads when it is empty or everything
    // after it up to the output is able to move
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_flow
            assign en[g] = m_tready || !(&vld_reg[NST-1:g]);
            if (g == 0)
            begin : g_first
                assign vld_next[g] = en[g] ? s_tvalid : vld_reg[g];
            end
            else
            begin : g_rest
                assign vld_next[g] = en[g] ? vld_reg[g-1] : vld_reg[g];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[ST_OUT];

    // stage 1: L = O - C
    s1_t  s1_reg, s1_next;
    ray_t in_ray;

    always_comb
    begin
        in_ray.ox = s_tdata[23:0];
        in_ray.oy = s_tdata[47:24];
        in_ray.oz = s_tdata[71:48];
        in_ray.dx = s_tdata[87:72];
        in_ray.dy = s_tdata[103:88];
        in_ray.dz = s_tdata[119:104];
        s1_next.ray = in_ray;
        s1_next.lx = $signed({in_ray.ox[23], in_ray.ox})
                   - $signed({center_x_reg[23], center_x_reg});
        s1_next.ly = $signed({in_ray.oy[23], in_ray.oy})
                   - $signed({center_y_reg[23], center_y_reg});
        s1_next.lz = $signed({in_ray.oz[23], in_ray.oz})
                   - $signed({center_z_reg[23], center_z_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            s1_reg <= s1_next;
    end

    // stage 2: products D*L, L*L and r*r
    s2_t s2_reg, s2_next;

    always_comb
    begin
        s2_next.ray = s1_reg.ray;
        s2_next.pdx = $signed(s1_reg.ray.dx) * s1_reg.lx;
        s2_next.pdy = $signed(s1_reg.ray.dy) * s1_reg.ly;
        s2_next.pdz = $signed(s1_reg.ray.dz) * s1_reg.lz;
        s2_next.plx = s1_reg.lx * s1_reg.lx;
        s2_next.ply = s1_reg.ly * s1_reg.ly;
        s2_next.plz = s1_reg.lz * s1_reg.lz;
        s2_next.rr  = radius_reg * radius_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            s2_reg <= s2_next;
    end

    // stage 3: b rounded to Q.12, |L|^2
    s3_t                s3_reg, s3_next;
    logic signed [42:0] bsum;

    always_comb
    begin
        bsum = 43'(s2_reg.pdx) + 43'(s2_reg.pdy) + 43'(s2_reg.pdz) + 43'sd8192;
        s3_next.ray = s2_reg.ray;
        s3_next.b   = bsum[42:14];
        s3_next.ll  = 52'(s2_reg.plx) + 52'(s2_reg.ply) + 52'(s2_reg.plz);
        s3_next.rr  = s2_reg.rr;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
            s3_reg <= s3_next;
    end

    // stage 4: b squared
    s4_t s4_reg, s4_next;

    always_comb
    begin
        s4_next.ray = s3_reg.ray;
        s4_next.b   = s3_reg.b;
        s4_next.bb  = s3_reg.b * s3_reg.b;
        s4_next.ll  = s3_reg.ll;
        s4_next.rr  = s3_reg.rr;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            s4_reg <= s4_next;
    end

    // stage 5: discriminant
    s5_t s5_reg, s5_next;

    always_comb
    begin
        s5_next.ray  = s4_reg.ray;
        s5_next.b    = s4_reg.b;
        s5_next.disc = 59'(s4_reg.bb) - 59'(s4_reg.ll) + $signed({13'd0, s4_reg.rr});
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
            s5_reg <= s5_next;
    end

    // stages 6..34: restoring square root, one root bit per stage
    sq_t sq_in   [SQRT_STEPS];
    sq_t sq_next [SQRT_STEPS];
    sq_t sq_reg  [SQRT_STEPS];

    always_comb
    begin
        sq_in[0].ray  = s5_reg.ray;
        sq_in[0].b    = s5_reg.b;
        sq_in[0].neg  = s5_reg.disc[58];
        sq_in[0].tan  = s5_reg.disc <= $signed({35'd0, epsilon_reg, 12'd0});
        sq_in[0].v    = s5_reg.disc[57:0];
        sq_in[0].rem  = '0;
        sq_in[0].root = '0;
    end

    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            logic [31:0] rem_sh;
            logic [31:0] trial;

            if (g > 0)
            begin : g_link
                assign sq_in[g] = sq_reg[g-1];
            end

            always_comb
            begin
                rem_sh = {sq_in[g].rem[29:0], sq_in[g].v[57:56]};
                trial  = {1'b0, sq_in[g].root, 2'b01};
                sq_next[g] = sq_in[g];
                sq_next[g].v = {sq_in[g].v[55:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    sq_next[g].rem  = rem_sh - trial;
                    sq_next[g].root = {sq_in[g].root[27:0], 1'b1};
                end
                else
                begin
                    sq_next[g].rem  = rem_sh;
                    sq_next[g].root = {sq_in[g].root[27:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[SQ_BASE + g])
                    sq_reg[g] <= sq_next[g];
            end
        end
    endgenerate

    // stage 35: t = -b - sqrt(disc), miss decision
    st_t         st_reg, st_next;
    sq_t         sq_last;
    logic [28:0] root_use;

    always_comb
    begin
        sq_last  = sq_reg[SQRT_STEPS-1];
        root_use = sq_last.tan ? 29'd0 : sq_last.root;
        st_next.ray  = sq_last.ray;
        st_next.t    = -$signed({{2{sq_last.b[28]}}, sq_last.b})
                     - $signed({2'b00, root_use});
        st_next.miss = sq_last.neg || (st_next.t <= $signed({19'd0, epsilon_reg}));
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_T])
            st_reg <= st_next;
    end

    // stage 36: D * t
    sdt_t sdt_reg, sdt_next;

    always_comb
    begin
        sdt_next.ox   = st_reg.ray.ox;
        sdt_next.oy   = st_reg.ray.oy;
        sdt_next.oz   = st_reg.ray.oz;
        sdt_next.t    = st_reg.t;
        sdt_next.miss = st_reg.miss;
        sdt_next.dtx  = $signed(st_reg.ray.dx) * st_reg.t;
        sdt_next.dty  = $signed(st_reg.ray.dy) * st_reg.t;
        sdt_next.dtz  = $signed(st_reg.ray.dz) * st_reg.t;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_DT])
            sdt_reg <= sdt_next;
    end

    // stage 37: hit point P = O + round(D*t)
    sp_t                sp_reg, sp_next;
    logic signed [46:0] rx, ry, rz;

    always_comb
    begin
        rx = sdt_reg.dtx + 47'sd8192;
        ry = sdt_reg.dty + 47'sd8192;
        rz = sdt_reg.dtz + 47'sd8192;
        sp_next.t    = sdt_reg.t;
        sp_next.miss = sdt_reg.miss;
        sp_next.px = $signed({{10{sdt_reg.ox[23]}}, sdt_reg.ox}) + $signed({rx[46], rx[46:14]});
        sp_next.py = $signed({{10{sdt_reg.oy[23]}}, sdt_reg.oy}) + $signed({ry[46], ry[46:14]});
        sp_next.pz = $signed({{10{sdt_reg.oz[23]}}, sdt_reg.oz}) + $signed({rz[46], rz[46:14]});
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_P])
            sp_reg <= sp_next;
    end

    // stage 38: P - C, saturated point and distance
    spc_t spc_reg, spc_next;

    always_comb
    begin
        spc_next.miss     = sp_reg.miss;
        spc_next.distance = (sp_reg.t > 31'sd16777215) ? 24'hFFFFFF : sp_reg.t[23:0];
        spc_next.ptx  = sat_point(sp_reg.px);
        spc_next.pty  = sat_point(sp_reg.py);
        spc_next.ptz  = sat_point(sp_reg.pz);
        spc_next.pcx  = 35'(sp_reg.px) - $signed({{11{center_x_reg[23]}}, center_x_reg});
        spc_next.pcy  = 35'(sp_reg.py) - $signed({{11{center_y_reg[23]}}, center_y_reg});
        spc_next.pcz  = 35'(sp_reg.pz) - $signed({{11{center_z_reg[23]}}, center_z_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PC])
            spc_reg <= spc_next;
    end

    // stage 39: (P - C) * inv_radius
    snp_t               snp_reg, snp_next;
    logic signed [23:0] inv_s;

    always_comb
    begin
        inv_s = $signed({1'b0, inv_radius_reg});
        snp_next.distance = spc_reg.distance;
        snp_next.miss = spc_reg.miss;
        snp_next.ptx  = spc_reg.ptx;
        snp_next.pty  = spc_reg.pty;
        snp_next.ptz  = spc_reg.ptz;
        snp_next.nx   = spc_reg.pcx * inv_s;
        snp_next.ny   = spc_reg.pcy * inv_s;
        snp_next.nz   = spc_reg.pcz * inv_s;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_NP])
            snp_reg <= snp_next;
    end

    // stage 40: output register, normal rounding, zero word on a miss
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    always_comb
    begin
        if (snp_reg.miss)
            m_tdata_next = '0;
        else
            m_tdata_next = {7'd0,
                            sat_normal(snp_reg.nz),
                            sat_normal(snp_reg.ny),
                            sat_normal(snp_reg.nx),
                            snp_reg.ptz, snp_reg.pty, snp_reg.ptx,
                            snp_reg.distance, 1'b1};
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tdata = m_tdata_reg;

    // a miss word carries nothing but zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[OUT_DATA_W-1:1] == '0)
        else $error("miss word has nonzero payload");

    // a hit always lies beyond the tolerance
    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[24:1] > {12'd0, epsilon_reg})
        else $error("hit distance not beyond epsilon");

    // input backpressure only when the whole pipeline is full and stalled
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready && (&vld_reg))
        else $error("input stalled with room in the pipeline");

endmodule

// ----- bench/ray_sphere_intersect_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the ray / sphere intersector
// needs rsi_pkg and ray_sphere_intersect; the hit prediction is computed in the bench itself
module ray_sphere_intersect_tb;
    import rsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    // one ray word and one result word as plain fields
    typedef struct {
        logic signed [23:0] ox, oy, oz;
        logic signed [15:0] dx, dy, dz;
    } ray_in_t;

    typedef struct {
        logic               hit;
        logic [23:0]        distance;
        logic signed [23:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
    } hit_rec_t;

    // directed row: a ray plus an optional typed-in expectation
    typedef struct {
        ray_in_t  ray;
        bit       fixed;
        hit_rec_t want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [2:0]            cfg_index;
    logic [23:0]           cfg_data;

    // sphere as the bench believes it is loaded
    longint sph_cx, sph_cy, sph_cz, sph_r, sph_inv, sph_eps;

    hit_rec_t pending_hits[$];
    int       err_count;
    int       rays_sent;
    int       results_seen;
    int       hits_seen;
    int       idle_cycles;
    bit       sink_calm;
    bit       src_calm;

    ray_sphere_intersect u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor division by 2^k after adding half, i.e. round half up
    function automatic longint round_half_up(longint x, int k);
        longint y;
        y = x + (longint'(1) <<< (k - 1));
        return y >>> k;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // floor of the integer square root, bit by bit
    function automatic longint int_sqrt(longint v);
        longint root;
        longint bitv;
        root = 0;
        bitv = longint'(1) <<< 62;
        while (bitv > v)
            bitv = bitv >>> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >>> 1) + bitv;
            end
            else
                root = root >>> 1;
            bitv = bitv >>> 2;
        end
        return root;
    endfunction

    // intersection of one ray with the loaded sphere
    function automatic hit_rec_t sphere_hit(ray_in_t r);
        hit_rec_t res;
        longint   o[3], d[3], c[3], l[3], p[3];
        longint   b26, b, ll, disc, t, n;
        res = '{default: '0};
        o = '{longint'(r.ox), longint'(r.oy), longint'(r.oz)};
        d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        c = '{sph_cx, sph_cy, sph_cz};
        b26 = 0;
        ll  = 0;
        for (int i = 0; i < 3; i++)
        begin
            l[i] = o[i] - c[i];
            b26 += d[i] * l[i];
            ll  += l[i] * l[i];
        end
        b    = round_half_up(b26, 14);
        disc = b * b - ll + sph_r * sph_r;
        if (disc < 0)
            return res;
        // near-tangent rays skip the root
        if (disc <= sph_eps * 4096)
            t = -b;
        else
            t = -b - int_sqrt(disc);
        // behind the origin, or origin inside the sphere
        if (t <= sph_eps)
            return res;
        res.hit      = 1'b1;
        res.distance = 24'(clip(t, 0, 16777215));
        for (int i = 0; i < 3; i++)
        begin
            p[i] = o[i] + round_half_up(d[i] * t, 14);
            // normal from the unclamped point
            n = clip(round_half_up((p[i] - c[i]) * sph_inv, 10), -16384, 16384);
            p[i] = clip(p[i], -8388608, 8388607);
            case (i)
                0: begin res.px = 24'(p[i]); res.nx = 16'(n); end
                1: begin res.py = 24'(p[i]); res.ny = 16'(n); end
                default: begin res.pz = 24'(p[i]); res.nz = 16'(n); end
            endcase
        end
        return res;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_ray(ray_in_t r);
        return {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
    endfunction

    function automatic hit_rec_t unpack_hit(logic [OUT_DATA_W-1:0] w);
        hit_rec_t h;
        h.hit      = w[0];
        h.distance = w[24:1];
        h.px   = w[48:25];
        h.py   = w[72:49];
        h.pz   = w[96:73];
        h.nx   = w[112:97];
        h.ny   = w[128:113];
        h.nz   = w[144:129];
        return h;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        err_count++;
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
    endtask

    // output side: random stalls, compare each word against the oldest expectation
    initial
    begin
        int burst;
        hit_rec_t got, want;
        m_tready = 1'b0;
        burst = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = unpack_hit(m_tdata);
                if (pending_hits.size() == 0)
                begin
                    err_count++;
                    $display("result word with no ray waiting for it");
                end
                else
                begin
                    want = pending_hits.pop_front();
                    if (got.hit !== want.hit)   report_mismatch("hit", got.hit, want.hit);
                    if (got.distance !== want.distance)
                        report_mismatch("distance", got.distance, want.distance);
                    if (got.px !== want.px)     report_mismatch("point_x", got.px, want.px);
                    if (got.py !== want.py)     report_mismatch("point_y", got.py, want.py);
                    if (got.pz !== want.pz)     report_mismatch("point_z", got.pz, want.pz);
                    if (got.nx !== want.nx)     report_mismatch("surf_nx", got.nx, want.nx);
                    if (got.ny !== want.ny)     report_mismatch("surf_ny", got.ny, want.ny);
                    if (got.nz !== want.nz)     report_mismatch("surf_nz", got.nz, want.nz);
                    if (m_tdata[151:145] !== '0) report_mismatch("pad", m_tdata[151:145], 0);
                    if (got.hit === 1'b1)
                        hits_seen++;
                end
                results_seen++;
            end
            if (burst > 0)
            begin
                burst--;
                m_tready <= 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 9) == 0)
            begin
                // stall: m_tready drops now and stays low while the remaining count runs down
                burst = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: cycles with no accepted word on any channel
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !rst_n)
                idle_cycles = 0;
            else if (s_tvalid || pending_hits.size() != 0 || cfg_valid)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", pending_hits.size());
                $display("ray_sphere_intersect_tb NOT OK");
                $finish;
            end
        end
    end

    // one register write, taken when cfg_ready; the caller drops cfg_valid
    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CENTER_X:   sph_cx  = longint'($signed(val));
            CFG_CENTER_Y:   sph_cy  = longint'($signed(val));
            CFG_CENTER_Z:   sph_cz  = longint'($signed(val));
            CFG_RADIUS:     sph_r   = longint'(val[22:0]);
            CFG_INV_RADIUS: sph_inv = longint'(val[22:0]);
            default:        sph_eps = longint'(val[11:0]);
        endcase
    endtask

    task automatic load_sphere(logic [23:0] cx, logic [23:0] cy, logic [23:0] cz,
                               logic [22:0] r, logic [22:0] inv, logic [11:0] eps);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, {1'b0, r});
        write_reg(CFG_INV_RADIUS, {1'b0, inv});
        write_reg(CFG_EPSILON, {12'd0, eps});
        cfg_valid <= 1'b0;
    endtask

    // block until the pipeline has handed back everything
    task automatic wait_drained();
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // present one ray, hold it until taken, optional gap afterwards
    task automatic send_ray(ray_in_t r, bit fixed, hit_rec_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_ray(r);
        do
            @(posedge clk);
        while (!s_tready);
        pending_hits.push_back(fixed ? want : sphere_hit(r));
        rays_sent++;
        if (!src_calm && $urandom_range(0, 11) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // unit-ish direction, mostly close to the z axis, sometimes any pattern
    function automatic ray_in_t aimed_ray(longint span);
        ray_in_t r;
        int      sel;
        longint  cx, cy, cz;
        cx = sph_cx; cy = sph_cy; cz = sph_cz;
        sel = $urandom_range(0, 9);
        r.ox = 24'(clip(cx + $signed($urandom_range(0, 2 * span)) - span, -8388608, 8388607));
        r.oy = 24'(clip(cy + $signed($urandom_range(0, 2 * span)) - span, -8388608, 8388607));
        r.oz = 24'(clip(cz - 3 * span - $urandom_range(0, span), -8388608, 8388607));
        r.dx = 16'($signed($urandom_range(0, 4000)) - 2000);
        r.dy = 16'($signed($urandom_range(0, 4000)) - 2000);
        r.dz = 16'(16200 + $urandom_range(0, 184));
        if (sel == 0)
        begin
            r.ox = 24'($urandom);
            r.oy = 24'($urandom);
            r.oz = 24'($urandom);
            r.dx = 16'($urandom);
            r.dy = 16'($urandom);
            r.dz = 16'($urandom);
        end
        else if (sel == 1)
            r.dz = -r.dz;
        return r;
    endfunction

    initial
    begin
        dir_row_t rows[$];
        hit_rec_t none;
        hit_rec_t ref_hit;
        ray_in_t  r;
        longint   span;

        err_count = 0; rays_sent = 0; results_seen = 0; hits_seen = 0;
        sink_calm = 1'b0;
        src_calm  = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CENTER_X;
        cfg_data  = '0;
        sph_cx = 0; sph_cy = 0; sph_cz = 0;
        sph_r = RADIUS_RST; sph_inv = INV_RAD_RST; sph_eps = EPS_RST;
        none = '{default: '0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit sphere at the origin, straight-on hit from z = -4 down +z
        ref_hit = '{1'b1, 24'd12288, 24'sd0, 24'sd0, -24'sd4096, 16'sd0, 16'sd0, -16'sd16384};
        rows.push_back('{'{0, 0, -16384, 0, 0, 16384}, 1'b1, ref_hit});
        // same ray pointing away: behind the origin
        rows.push_back('{'{0, 0, -16384, 0, 0, -16384}, 1'b1, none});
        // origin inside the sphere
        rows.push_back('{'{0, 0, 0, 0, 0, 16384}, 1'b1, none});
        // clear miss off to the side
        rows.push_back('{'{24'sd20000, 0, -16384, 0, 0, 16384}, 1'b1, none});
        // grazing the silhouette at x = r
        rows.push_back('{'{24'sd4096, 0, -16384, 0, 0, 16384}, 1'b0, none});
        rows.push_back('{'{24'sd4095, 0, -16384, 0, 0, 16384}, 1'b0, none});
        // field extremes and raw direction patterns
        rows.push_back('{'{-24'sd8388608, -24'sd8388608, -24'sd8388608,
                           16'sd16384, 16'sd16384, 16'sd16384}, 1'b0, none});
        rows.push_back('{'{24'sd8388607, 24'sd8388607, 24'sd8388607,
                           -16'sd16384, -16'sd16384, -16'sd16384}, 1'b0, none});
        rows.push_back('{'{-24'sd8388608, 0, 0, 16'sd16384, 0, 0}, 1'b0, none});
        rows.push_back('{'{24'sd8388607, 0, 0, -16'sd16384, 0, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, -16384, -16'sd32768, 16'sd32767, 16'sd32767}, 1'b0, none});
        rows.push_back('{'{0, 0, -16384, 16'sd32767, -16'sd32768, -16'sd32768}, 1'b0, none});
        rows.push_back('{'{0, 0, -16384, 0, 0, 0}, 1'b1, none});
        rows.push_back('{'{0, -24'sd8388608, 0, 0, 16'sd16384, 0}, 1'b0, none});
        foreach (rows[i])
            send_ray(rows[i].ray, rows[i].fixed, rows[i].want);
        s_tvalid <= 1'b0;
        // hold off until the directed rays are all back
        wait_drained();

        // extreme sphere: far corner, largest radius, epsilon at its top, then zero radius
        load_sphere(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 12'hFFF);
        send_ray('{-24'sd8388608, 24'sd8388607, -24'sd8388608, 16'sd9459, -16'sd9459, 16'sd9459},
                 1'b0, none);
        send_ray('{0, 0, 0, 16'sd16384, 0, 0}, 1'b0, none);
        s_tvalid <= 1'b0;
        wait_drained();
        load_sphere(24'h800000, 24'h000000, 24'h800000, 23'd0, 23'd0, 12'd0);
        send_ray('{-24'sd8388608, 0, -24'sd8400000, 0, 0, 16'sd16384}, 1'b0, none);
        send_ray('{-24'sd8388608, 24'sd10, -24'sd8388000, 0, 0, -16'sd16384}, 1'b0, none);
        s_tvalid <= 1'b0;
        wait_drained();

        // random phases, each with its own sphere
        for (int ph = 0; ph < 11; ph++)
        begin
            span = (ph % 3 == 0) ? 4096 * 40 : 4096 * 4;
            if (ph == 10)
            begin
                // last stretch without idling on either side
                sink_calm = 1'b1;
                src_calm  = 1'b1;
            end
            load_sphere(24'($signed($urandom_range(0, 400000)) - 200000),
                        24'($signed($urandom_range(0, 400000)) - 200000),
                        24'($signed($urandom_range(0, 400000)) - 200000),
                        23'(span / 4 + $urandom_range(0, span / 4)),
                        23'($urandom_range(0, 8388607)),
                        12'($urandom_range(0, (ph % 2) ? 4095 : 8)));
            for (int k = 0; k < 100; k++)
                send_ray(aimed_ray(span), 1'b0, none);
            s_tvalid <= 1'b0;
            wait_drained();
        end

        $display("%0d rays sent, %0d results checked, %0d hits, over 14 sphere settings",
                 rays_sent, results_seen, hits_seen);
        $display("covered tangent, behind, inside, extreme-field and raw-direction cases");
        if (err_count == 0 && pending_hits.size() == 0)
            $display("ray_sphere_intersect_tb OK");
        else
            $display("ray_sphere_intersect_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rsi_pkg.sv
design/ray_sphere_intersect.sv
bench/ray_sphere_intersect_tb.sv
